// File: design/scm_pkg.sv
package scm_pkg;

  localparam int COORD_BITS = 32;
  localparam int FRAC_BITS  = 16;

  // Coordinate differences, projected offsets and magnitudes.
  localparam int DIFF_W = COORD_BITS + 1;
  localparam int ERR_W  = COORD_BITS + 3;
  localparam int MAG_W  = COORD_BITS + 2;
  localparam int HALF_W = MAG_W / 2;

  // Sums of squares, accumulator, roots and the divider remainder.
  localparam int SQ_W   = 2 * MAG_W + 2;
  localparam int ACC_W  = SQ_W + 2;
  localparam int ROOT_W = SQ_W / 2;
  localparam int SEG_W  = 2 * COORD_BITS + 2;
  localparam int DIV_W  = SEG_W + 1;
  localparam int T_W    = 32;

  localparam int RADIUS_W = 21;
  localparam int SEP_W    = 32;
  localparam int CLR_W    = 32;
  localparam int OSEP_W   = 31;

  localparam logic [SEG_W-1:0] EPS_RAW =
    SEG_W'(((64'd1 << (2 * FRAC_BITS)) + 64'd50000) / 64'd100000);
  localparam logic [RADIUS_W-1:0] RADIUS_RESET =
    RADIUS_W'(((64'd15 << FRAC_BITS) + 64'd50) / 64'd100);
  localparam logic [SEP_W-1:0] SEP_RESET = '1;
  localparam logic signed [CLR_W-1:0] CLR_RESET = {1'b0, {(CLR_W-1){1'b1}}};

  typedef logic signed [DIFF_W-1:0] diff_t;

  // One classified item: the three difference vectors and its flags.
  typedef struct packed {
    diff_t dx;
    diff_t dy;
    diff_t dz;
    diff_t wx;
    diff_t wy;
    diff_t wz;
    diff_t vx;
    diff_t vy;
    diff_t vz;
    logic  present;
    logic  last;
  } item_t;

endpackage

// File: design/segment_clearance_minimum.sv
// Per-frame line-of-sight clearance. Each transfer on the in_ channel brings
// keeper, target and one obstacle position (signed Q16.16). The block tracks
// the smallest keeper-target or keeper-obstacle distance and the smallest
// distance from an obstacle to the keeper-target segment minus the configured
// radius, or the keeper-target distance for a degenerate segment; the transfer
// with in_frame_end set produces one out_ transfer with both minima and starts
// the next frame from the reset values. A frame with no obstacle reports
// 0x7FFFFFFF as its clearance. The user must write the radius through the
// cfg_ channel while the block is idle; the block does not enforce this. The
// radius resets to 0.15 m. An item with an obstacle takes longest when the
// projection falls inside the segment, less when the keeper or the target is
// the closest point, and least when the segment is degenerate; an item
// without one is shorter still. A frame-end item also waits while a previous
// result is stalled. The work is set by the shared square-root unit, which
// resolves one root bit per cycle (up to three roots per item), the projection
// divider, and the shared multiplier, which adds two half-width products.
module segment_clearance_minimum #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_keeper_x,
  input  logic signed [31:0] in_keeper_y,
  input  logic signed [31:0] in_keeper_z,
  input  logic signed [31:0] in_target_x,
  input  logic signed [31:0] in_target_y,
  input  logic signed [31:0] in_target_z,
  input  logic signed [31:0] in_obstacle_x,
  input  logic signed [31:0] in_obstacle_y,
  input  logic signed [31:0] in_obstacle_z,
  input  logic               in_obstacle_present,
  input  logic               in_frame_end,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [30:0]        out_min_separation,
  output logic signed [31:0] out_min_clearance,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [20:0]        cfg_data
);
  import scm_pkg::*;

  item_t f_item;
  item_t q_item;
  logic  q_full;
  logic  q_empty;
  logic  q_pop;
  logic  q_push;

  // The front end forms the difference vectors as the item is taken, so the
  // queue holds ready-to-use operands and the back end never sees raw inputs.
  scm_front u_front (
    .keeper_x         (in_keeper_x),
    .keeper_y         (in_keeper_y),
    .keeper_z         (in_keeper_z),
    .target_x         (in_target_x),
    .target_y         (in_target_y),
    .target_z         (in_target_z),
    .obstacle_x       (in_obstacle_x),
    .obstacle_y       (in_obstacle_y),
    .obstacle_z       (in_obstacle_z),
    .obstacle_present (in_obstacle_present),
    .frame_end        (in_frame_end),
    .item             (f_item)
  );

  // Items are taken as long as the queue has room, independent of how long
  // the back end spends on the current one.
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  scm_fifo #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (f_item),
    .pop       (q_pop),
    .pop_item  (q_item),
    .full      (q_full),
    .empty     (q_empty)
  );

  // The radius register can always take a write.
  assign cfg_ready = 1'b1;

  scm_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_empty            (q_empty),
    .q_item             (q_item),
    .q_pop              (q_pop),
    .cfg_we             (cfg_valid),
    .cfg_data           (cfg_data),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_min_separation (out_min_separation),
    .out_min_clearance  (out_min_clearance)
  );

endmodule

// File: design/scm_front.sv
module scm_front (
  input  logic signed [31:0] keeper_x,
  input  logic signed [31:0] keeper_y,
  input  logic signed [31:0] keeper_z,
  input  logic signed [31:0] target_x,
  input  logic signed [31:0] target_y,
  input  logic signed [31:0] target_z,
  input  logic signed [31:0] obstacle_x,
  input  logic signed [31:0] obstacle_y,
  input  logic signed [31:0] obstacle_z,
  input  logic               obstacle_present,
  input  logic               frame_end,
  output scm_pkg::item_t     item
);
  import scm_pkg::*;

  function automatic diff_t sub_c(input logic signed [31:0] a, input logic signed [31:0] b);
    logic signed [COORD_BITS-1:0] ac;
    logic signed [COORD_BITS-1:0] bc;
    ac = a[COORD_BITS-1:0];
    bc = b[COORD_BITS-1:0];
    sub_c = DIFF_W'(ac) - DIFF_W'(bc);
  endfunction

  // Segment direction, obstacle relative to the target, keeper relative to the obstacle.
  always_comb begin
    item.dx      = sub_c(keeper_x, target_x);
    item.dy      = sub_c(keeper_y, target_y);
    item.dz      = sub_c(keeper_z, target_z);
    item.wx      = sub_c(obstacle_x, target_x);
    item.wy      = sub_c(obstacle_y, target_y);
    item.wz      = sub_c(obstacle_z, target_z);
    item.vx      = sub_c(keeper_x, obstacle_x);
    item.vy      = sub_c(keeper_y, obstacle_y);
    item.vz      = sub_c(keeper_z, obstacle_z);
    item.present = obstacle_present;
    item.last    = frame_end;
  end

endmodule

// File: design/scm_fifo.sv
module scm_fifo #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  scm_pkg::item_t push_item,
  input  logic           pop,
  output scm_pkg::item_t pop_item,
  output logic           full,
  output logic           empty
);
  import scm_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t         mem_r [DEPTH];
  logic [AW-1:0] wp_r;
  logic [AW-1:0] rp_r;
  logic [CW-1:0] cnt_r;

  assign full     = (cnt_r == CW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_item = mem_r[rp_r];

  function automatic logic [AW-1:0] wrap(input logic [AW-1:0] p);
    wrap = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wrap(wp_r);
      if (pop)  rp_r <= wrap(rp_r);
      if (push && !pop) cnt_r <= cnt_r + CW'(1);
      else if (pop && !push) cnt_r <= cnt_r - CW'(1);
    end
  end

endmodule

// File: design/scm_back.sv
module scm_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             q_empty,
  input  scm_pkg::item_t                   q_item,
  output logic                             q_pop,
  input  logic                             cfg_we,
  input  logic [scm_pkg::RADIUS_W-1:0]     cfg_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [scm_pkg::OSEP_W-1:0]       out_min_separation,
  output logic signed [scm_pkg::CLR_W-1:0] out_min_clearance
);
  import scm_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MUL    = 3'd1;
  localparam logic [2:0] ST_POST   = 3'd2;
  localparam logic [2:0] ST_SQRT   = 3'd3;
  localparam logic [2:0] ST_SQDONE = 3'd4;
  localparam logic [2:0] ST_DIV    = 3'd5;
  localparam logic [2:0] ST_FIN    = 3'd6;

  localparam logic [2:0] OP_SEG = 3'd0;
  localparam logic [2:0] OP_KO  = 3'd1;
  localparam logic [2:0] OP_DOT = 3'd2;
  localparam logic [2:0] OP_OFF = 3'd3;
  localparam logic [2:0] OP_EE  = 3'd4;

  localparam int SC_W = ROOT_W + 2;
  localparam logic [5:0] SQ_LAST  = 6'(ROOT_W - 1);
  localparam logic [5:0] DIV_LAST = 6'(T_W - 1);

  logic [2:0]                state_r;
  logic [2:0]                op_r;
  logic [1:0]                idx_r;
  logic                      half_r;
  logic [5:0]                cnt_r;
  item_t                     it_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic [SEG_W-1:0]          seg_r;
  logic [SEP_W-1:0]          kt_r;
  logic signed [ERR_W-1:0]   e_r [3];
  logic [SQ_W-1:0]           sqv_r;
  logic [ROOT_W+1:0]         rem_r;
  logic [ROOT_W-1:0]         root_r;
  logic [DIV_W-1:0]          div_r;
  logic [T_W-1:0]            t_r;
  logic [RADIUS_W-1:0]       radius_r;
  logic [SEP_W-1:0]          sep_r;
  logic signed [CLR_W-1:0]   clr_r;
  logic                      out_valid_r;
  logic [OSEP_W-1:0]         osep_r;
  logic signed [CLR_W-1:0]   oclr_r;

  function automatic logic [MAG_W-1:0] mag_d(input diff_t v);
    logic signed [MAG_W-1:0] x;
    x = MAG_W'(v);
    mag_d = (x < 0) ? -x : x;
  endfunction

  function automatic logic [MAG_W-1:0] mag_e(input logic signed [ERR_W-1:0] v);
    logic signed [ERR_W-1:0] x;
    x = (v < 0) ? -v : v;
    mag_e = x[MAG_W-1:0];
  endfunction

  // Operand selection for the shared multiply-accumulate.
  diff_t                   d_sel, w_sel, v_sel;
  logic signed [ERR_W-1:0] e_sel;
  logic [MAG_W-1:0]        a_op, b_op;
  logic                    neg_op;
  logic [HALF_W-1:0]       b_half;
  logic [MAG_W+HALF_W-1:0] pp;
  logic [ACC_W-1:0]        contrib;
  logic signed [ACC_W-1:0] acc_nxt;

  always_comb begin
    case (idx_r)
      2'd0:    begin d_sel = it_r.dx; w_sel = it_r.wx; v_sel = it_r.vx; end
      2'd1:    begin d_sel = it_r.dy; w_sel = it_r.wy; v_sel = it_r.vy; end
      default: begin d_sel = it_r.dz; w_sel = it_r.wz; v_sel = it_r.vz; end
    endcase
    e_sel  = e_r[idx_r];
    neg_op = 1'b0;
    case (op_r)
      OP_SEG:  begin a_op = mag_d(d_sel); b_op = a_op; end
      OP_KO:   begin a_op = mag_d(v_sel); b_op = a_op; end
      OP_DOT:  begin
        a_op   = mag_d(w_sel);
        b_op   = mag_d(d_sel);
        neg_op = w_sel[DIFF_W-1] ^ d_sel[DIFF_W-1];
      end
      OP_OFF:  begin a_op = mag_d(d_sel); b_op = MAG_W'(t_r); end
      OP_EE:   begin a_op = mag_e(e_sel); b_op = a_op; end
      default: begin a_op = '0; b_op = '0; end
    endcase
    b_half  = half_r ? b_op[MAG_W-1:HALF_W] : b_op[HALF_W-1:0];
    pp      = a_op * b_half;
    contrib = half_r ? (ACC_W'(pp) << HALF_W) : ACC_W'(pp);
    acc_nxt = neg_op ? acc_r - $signed(contrib) : acc_r + $signed(contrib);
  end

  // One root bit per cycle.
  logic [ROOT_W+3:0] sq_rem2, sq_trial;
  logic              sq_ge;
  logic [ROOT_W+1:0] rem_nxt;
  logic [ROOT_W-1:0] root_nxt;

  always_comb begin
    sq_rem2  = {rem_r, sqv_r[SQ_W-1:SQ_W-2]};
    sq_trial = (ROOT_W+4)'({root_r, 2'b01});
    sq_ge    = (sq_rem2 >= sq_trial);
    rem_nxt  = sq_ge ? (ROOT_W+2)'(sq_rem2 - sq_trial) : (ROOT_W+2)'(sq_rem2);
    root_nxt = {root_r[ROOT_W-2:0], sq_ge};
  end

  // One quotient bit per cycle.
  logic [DIV_W:0]   dv_sh;
  logic             dv_ge;
  logic [DIV_W-1:0] div_nxt;

  always_comb begin
    dv_sh   = {div_r, 1'b0};
    dv_ge   = (dv_sh >= (DIV_W+1)'(seg_r));
    div_nxt = dv_ge ? DIV_W'(dv_sh - (DIV_W+1)'(seg_r)) : DIV_W'(dv_sh);
  end

  // Rounded projected offset and the residual it leaves.
  logic [ACC_W-1:0]        off_rnd;
  logic signed [ERR_W-1:0] off_v, w_ext, e_nxt;

  always_comb begin
    off_rnd = $unsigned(acc_r) + (ACC_W'(1) << (T_W - 1));
    off_v   = $signed(off_rnd[T_W+ERR_W-1:T_W]);
    w_ext   = ERR_W'(w_sel);
    e_nxt   = d_sel[DIFF_W-1] ? w_ext + off_v : w_ext - off_v;
  end

  // Scores and saturated distances.
  logic [SEP_W-1:0]        root_sat;
  logic signed [SC_W-1:0]  ee_score;
  logic signed [CLR_W-1:0] ee_cand, kt_cand;
  logic                    emit_ok;

  always_comb begin
    root_sat = (|root_r[ROOT_W-1:SEP_W]) ? SEP_RESET : root_r[SEP_W-1:0];
    ee_score = $signed(SC_W'(root_r)) - $signed(SC_W'(radius_r));
    ee_cand  = (ee_score > SC_W'(CLR_RESET)) ? CLR_RESET : ee_score[CLR_W-1:0];
    kt_cand  = kt_r[SEP_W-1] ? CLR_RESET : $signed({1'b0, kt_r[SEP_W-2:0]});
    emit_ok  = !out_valid_r || !out_stall;
  end

  assign q_pop              = (state_r == ST_IDLE) && !q_empty;
  assign out_valid          = out_valid_r;
  assign out_min_separation = osep_r;
  assign out_min_clearance  = oclr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      radius_r    <= RADIUS_RESET;
      sep_r       <= SEP_RESET;
      clr_r       <= CLR_RESET;
    end else begin
      if (cfg_we) radius_r <= cfg_data;
      if (out_valid_r && !out_stall && !(state_r == ST_FIN && it_r.last)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (!q_empty) begin
            it_r    <= q_item;
            op_r    <= OP_SEG;
            idx_r   <= 2'd0;
            half_r  <= 1'b0;
            acc_r   <= '0;
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          acc_r <= acc_nxt;
          if (!half_r) begin
            half_r <= 1'b1;
          end else begin
            half_r <= 1'b0;
            if (op_r == OP_OFF || idx_r == 2'd2) state_r <= ST_POST;
            else idx_r <= idx_r + 2'd1;
          end
        end
        ST_POST: begin
          case (op_r)
            OP_DOT: begin
              if (acc_r <= 0) begin
                e_r[0]  <= ERR_W'(it_r.wx);
                e_r[1]  <= ERR_W'(it_r.wy);
                e_r[2]  <= ERR_W'(it_r.wz);
                op_r    <= OP_EE;
                idx_r   <= 2'd0;
                acc_r   <= '0;
                state_r <= ST_MUL;
              end else if (acc_r >= $signed(ACC_W'(seg_r))) begin
                e_r[0]  <= ERR_W'(it_r.wx) - ERR_W'(it_r.dx);
                e_r[1]  <= ERR_W'(it_r.wy) - ERR_W'(it_r.dy);
                e_r[2]  <= ERR_W'(it_r.wz) - ERR_W'(it_r.dz);
                op_r    <= OP_EE;
                idx_r   <= 2'd0;
                acc_r   <= '0;
                state_r <= ST_MUL;
              end else begin
                div_r   <= acc_r[DIV_W-1:0];
                t_r     <= '0;
                cnt_r   <= '0;
                state_r <= ST_DIV;
              end
            end
            OP_OFF: begin
              e_r[idx_r] <= e_nxt;
              acc_r      <= '0;
              state_r    <= ST_MUL;
              if (idx_r == 2'd2) begin
                op_r  <= OP_EE;
                idx_r <= 2'd0;
              end else begin
                idx_r <= idx_r + 2'd1;
              end
            end
            default: begin
              if (op_r == OP_SEG) seg_r <= acc_r[SEG_W-1:0];
              sqv_r   <= acc_r[SQ_W-1:0];
              rem_r   <= '0;
              root_r  <= '0;
              cnt_r   <= '0;
              state_r <= ST_SQRT;
            end
          endcase
        end
        ST_SQRT: begin
          sqv_r  <= sqv_r << 2;
          rem_r  <= rem_nxt;
          root_r <= root_nxt;
          cnt_r  <= cnt_r + 6'd1;
          if (cnt_r == SQ_LAST) state_r <= ST_SQDONE;
        end
        ST_SQDONE: begin
          case (op_r)
            OP_SEG: begin
              kt_r <= root_sat;
              if (root_sat < sep_r) sep_r <= root_sat;
              if (it_r.present) begin
                op_r    <= OP_KO;
                idx_r   <= 2'd0;
                acc_r   <= '0;
                state_r <= ST_MUL;
              end else begin
                state_r <= ST_FIN;
              end
            end
            OP_KO: begin
              if (root_sat < sep_r) sep_r <= root_sat;
              if (seg_r < EPS_RAW) begin
                if (kt_cand < clr_r) clr_r <= kt_cand;
                state_r <= ST_FIN;
              end else begin
                op_r    <= OP_DOT;
                idx_r   <= 2'd0;
                acc_r   <= '0;
                state_r <= ST_MUL;
              end
            end
            default: begin
              if (ee_cand < clr_r) clr_r <= ee_cand;
              state_r <= ST_FIN;
            end
          endcase
        end
        ST_DIV: begin
          div_r <= div_nxt;
          t_r   <= {t_r[T_W-2:0], dv_ge};
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == DIV_LAST) begin
            op_r    <= OP_OFF;
            idx_r   <= 2'd0;
            acc_r   <= '0;
            state_r <= ST_MUL;
          end
        end
        ST_FIN: begin
          if (!it_r.last) begin
            state_r <= ST_IDLE;
          end else if (emit_ok) begin
            out_valid_r <= 1'b1;
            osep_r      <= sep_r[SEP_W-1] ? '1 : sep_r[OSEP_W-1:0];
            oclr_r      <= clr_r;
            sep_r       <= SEP_RESET;
            clr_r       <= CLR_RESET;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  a_sqrt_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SQRT) |-> (cnt_r <= SQ_LAST))
    else $error("root iteration count overran");

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (cnt_r <= DIV_LAST) && (op_r == OP_DOT))
    else $error("divider ran outside the projection step");

  a_frame_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && it_r.last && emit_ok) |=>
      (sep_r == SEP_RESET) && (clr_r == CLR_RESET) && out_valid_r)
    else $error("minima not returned to reset after frame result");

endmodule
